// ===== src/clyde_pkg.sv =====
// clyde_pkg: payload structs, round constants and the round functions of the
// clyde-128 tweakable cipher; no dependencies, used by every file in src
`timescale 1ns / 1ps

package clyde_pkg;

  localparam int ROUND_STEPS = 6;
  localparam int MAX_STEPS   = 6;
  localparam int CFG_IDX_W   = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 1'd1;

  typedef logic [31:0]       word_t;
  typedef logic [1:0][31:0]  pair_t;
  typedef logic [3:0][31:0]  block_t;

  typedef struct packed {
    logic        mode;
    logic [63:0] block_low;
    logic [63:0] block_high;
    logic [63:0] tweak_low;
    logic [63:0] tweak_high;
  } in_t;

  typedef struct packed {
    logic [63:0] result_low;
    logic [63:0] result_high;
  } out_t;

  // what travels between pipeline stages
  typedef struct packed {
    logic   mode;
    block_t s;
    block_t t;
  } stage_t;

  // bit h*4+w is the constant for word w in half h of a step
  localparam logic [7:0] STEP_CONST [MAX_STEPS] = '{
    8'h21, 8'h84, 8'h63, 8'hBC, 8'hA5, 8'hE7
  };

  function automatic word_t rol(input word_t x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic word_t ror(input word_t x, input int n);
    return rol(x, 32 - n);
  endfunction

  function automatic block_t sbox(input block_t s);
    word_t p, q;
    block_t r;
    p = (s[0] & s[1]) ^ s[2];
    q = (s[3] & s[0]) ^ s[1];
    r[0] = q;
    r[1] = p;
    r[2] = (p & q) ^ s[3];
    r[3] = (p & s[3]) ^ s[0];
    return r;
  endfunction

  function automatic block_t inv_sbox(input block_t s);
    word_t q, u, v;
    block_t r;
    q = (s[0] & s[1]) ^ s[2];
    u = (s[1] & q) ^ s[3];
    v = (q & u) ^ s[0];
    r[0] = u;
    r[1] = v;
    r[2] = (u & v) ^ s[1];
    r[3] = q;
    return r;
  endfunction

  function automatic pair_t lbox(input pair_t xy);
    word_t p, q, a, b;
    pair_t r;
    p = xy[0] ^ ror(xy[0], 12);
    q = xy[1] ^ ror(xy[1], 12);
    p = p ^ ror(p, 3);
    q = q ^ ror(q, 3);
    a = p ^ rol(xy[0], 15);
    b = q ^ rol(xy[1], 15);
    p = a ^ rol(a, 1);
    q = b ^ rol(b, 1);
    a = a ^ rol(q, 6);
    b = b ^ rol(p, 7);
    a = a ^ ror(p, 15);
    b = b ^ ror(q, 15);
    r[0] = a;
    r[1] = b;
    return r;
  endfunction

  function automatic pair_t inv_lbox(input pair_t xy);
    word_t p, q, a, b;
    pair_t r;
    a = xy[0];
    b = xy[1];
    p = a ^ rol(a, 7);
    q = b ^ rol(b, 7);
    a = a ^ rol(p, 1);
    b = b ^ rol(q, 1);
    a = a ^ rol(p, 12);
    b = b ^ rol(q, 12);
    p = a ^ rol(a, 1);
    q = b ^ rol(b, 1);
    a = a ^ rol(q, 6);
    b = b ^ rol(p, 7);
    p = p ^ rol(a, 15);
    q = q ^ rol(b, 15);
    r[0] = ror(p, 16);
    r[1] = ror(q, 16);
    return r;
  endfunction

  function automatic block_t add_const(input block_t s, input logic [3:0] c);
    block_t r;
    r = s;
    for (int w = 0; w < 4; w++) begin
      r[w][0] = s[w][0] ^ c[w];
    end
    return r;
  endfunction

  function automatic block_t enc_round(input block_t s, input logic [3:0] c);
    block_t r;
    r = sbox(s);
    r[1:0] = lbox(r[1:0]);
    r[3:2] = lbox(r[3:2]);
    return add_const(r, c);
  endfunction

  function automatic block_t dec_round(input block_t s, input logic [3:0] c);
    block_t r;
    r = add_const(s, c);
    r[1:0] = inv_lbox(r[1:0]);
    r[3:2] = inv_lbox(r[3:2]);
    return inv_sbox(r);
  endfunction

  // (a, b) -> (a ^ b, a) on word pairs
  function automatic block_t tweak_fwd(input block_t t);
    block_t r;
    r[0] = t[0] ^ t[2];
    r[1] = t[1] ^ t[3];
    r[2] = t[0];
    r[3] = t[1];
    return r;
  endfunction

  function automatic block_t tweak_back(input block_t t);
    block_t r;
    r[0] = t[2];
    r[1] = t[3];
    r[2] = t[0] ^ t[2];
    r[3] = t[1] ^ t[3];
    return r;
  endfunction

endpackage

// ===== src/clyde_step.sv =====
// clyde_step: one elastic pipeline stage doing one cipher step (two rounds)
// in either direction; depends on clyde_pkg
`timescale 1ns / 1ps

module clyde_step #(
  parameter int ROUND_STEPS = clyde_pkg::ROUND_STEPS,
  parameter int STEP        = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  clyde_pkg::block_t key,
  input  logic              up_valid,
  output logic              up_ready,
  input  clyde_pkg::stage_t up_data,
  output logic              dn_valid,
  input  logic              dn_ready,
  output clyde_pkg::stage_t dn_data
);

  localparam int DEC_STEP = ROUND_STEPS - 1 - STEP;
  localparam logic [7:0] ENC_C = clyde_pkg::STEP_CONST[STEP];
  localparam logic [7:0] DEC_C = clyde_pkg::STEP_CONST[DEC_STEP];

  logic              valid_r;
  clyde_pkg::stage_t data_r;
  clyde_pkg::stage_t data_nxt;

  always_comb begin
    data_nxt = up_data;
    if (!up_data.mode) begin
      data_nxt.s = clyde_pkg::enc_round(up_data.s, ENC_C[3:0]);
      data_nxt.s = clyde_pkg::enc_round(data_nxt.s, ENC_C[7:4]);
      data_nxt.t = clyde_pkg::tweak_fwd(up_data.t);
      data_nxt.s = data_nxt.s ^ key ^ data_nxt.t;
    end else begin
      data_nxt.s = up_data.s ^ key ^ up_data.t;
      data_nxt.t = clyde_pkg::tweak_back(up_data.t);
      data_nxt.s = clyde_pkg::dec_round(data_nxt.s, DEC_C[7:4]);
      data_nxt.s = clyde_pkg::dec_round(data_nxt.s, DEC_C[3:0]);
    end
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

// ===== src/clyde128_tweakable_cipher.sv =====
// stages: an input transfer reaches out_valid through the entry stage, one
// stage per cipher step of two rounds and the exit stage
// throughput: one block per cycle unless the output stalls; each stage holds
// one block, so a stall at the output backs up through the stages without loss
// reset: synchronous active-low rst_n clears every stage valid and both key
// registers; stage payload registers are not reset
`timescale 1ns / 1ps

module clyde128_tweakable_cipher #(
  parameter int ROUND_STEPS = clyde_pkg::ROUND_STEPS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  clyde_pkg::in_t                 in_data,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output clyde_pkg::out_t                out_data,
  // key register writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [clyde_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                    cfg_data
);

  // key registers; the user must write them only while the pipeline is empty (not enforced)
  logic [63:0] key_low_r;
  logic [63:0] key_high_r;
  clyde_pkg::block_t key;

  assign cfg_ready = 1'b1;
  assign key       = {key_high_r, key_low_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r  <= '0;
      key_high_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        clyde_pkg::REG_KEY_LOW:  key_low_r  <= cfg_data;
        clyde_pkg::REG_KEY_HIGH: key_high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage handshake chain: index 0 is the entry stage, ROUND_STEPS the input
  // of the exit stage
  logic              valid [ROUND_STEPS+1];
  logic              ready [ROUND_STEPS+1];
  clyde_pkg::stage_t data  [ROUND_STEPS+1];

  // entry stage: encrypt whitens with the first tweakey, decrypt pre-advances
  // the tweak so the step stages walk it back to the original
  clyde_pkg::stage_t entry_nxt;
  logic              entry_valid_r;
  clyde_pkg::stage_t entry_r;

  always_comb begin
    entry_nxt.mode = in_data.mode;
    entry_nxt.s    = {in_data.block_high, in_data.block_low};
    entry_nxt.t    = {in_data.tweak_high, in_data.tweak_low};
    if (!in_data.mode) begin
      entry_nxt.s = entry_nxt.s ^ key ^ entry_nxt.t;
    end else begin
      for (int i = 0; i < ROUND_STEPS % 3; i++) begin
        entry_nxt.t = clyde_pkg::tweak_fwd(entry_nxt.t);
      end
    end
  end

  assign in_ready = !entry_valid_r || ready[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_valid_r <= 1'b0;
    end else if (in_ready) begin
      entry_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      entry_r <= entry_nxt;
    end
  end

  assign valid[0] = entry_valid_r;
  assign data[0]  = entry_r;

  // one stage per cipher step
  for (genvar g = 0; g < ROUND_STEPS; g++) begin : g_step
    clyde_step #(
      .ROUND_STEPS (ROUND_STEPS),
      .STEP        (g)
    ) u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .key      (key),
      .up_valid (valid[g]),
      .up_ready (ready[g]),
      .up_data  (data[g]),
      .dn_valid (valid[g+1]),
      .dn_ready (ready[g+1]),
      .dn_data  (data[g+1])
    );
  end

  // exit stage: decrypt adds the final tweakey; this is the output register
  clyde_pkg::block_t exit_nxt;
  logic              exit_valid_r;
  clyde_pkg::block_t exit_r;

  always_comb begin
    exit_nxt = data[ROUND_STEPS].s;
    if (data[ROUND_STEPS].mode) begin
      exit_nxt = data[ROUND_STEPS].s ^ key ^ data[ROUND_STEPS].t;
    end
  end

  assign ready[ROUND_STEPS] = !exit_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exit_valid_r <= 1'b0;
    end else if (ready[ROUND_STEPS]) begin
      exit_valid_r <= valid[ROUND_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (valid[ROUND_STEPS] && ready[ROUND_STEPS]) begin
      exit_r <= exit_nxt;
    end
  end

  assign out_valid            = exit_valid_r;
  assign out_data.result_low  = exit_r[1:0];
  assign out_data.result_high = exit_r[3:2];

  // a free output makes every stage free, so the input can always transfer
  a_ready_chain : assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("in_ready low while out_ready high");

  // the input only stalls when the pipeline is backed up from the output
  a_stall_source : assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without an output stall");

  // reset empties the pipeline
  a_reset_empty : assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

endmodule
